// ===== sv/csd_pkg.sv =====
// ----------------------------------------------------------------------------
// csd_pkg
// Shared types and constants of the compiled-sprite scanline decoder.
// ----------------------------------------------------------------------------
package csd_pkg;

   localparam int PALETTE_DEPTH = 256;
   localparam int PAL_ADDR_W    = 8;
   localparam int RGB_W         = 24;
   localparam int MAX_WIDTH     = 4096;

   // result kinds
   localparam logic [1:0] KIND_PIXEL = 2'd0;
   localparam logic [1:0] KIND_ROW   = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // one decoded event: an error, a finished row or a run of 1..4 pixels
   typedef struct packed {
      logic        valid;
      logic [1:0]  kind;
      logic [2:0]  err;
      logic [11:0] x0;
      logic [11:0] y;
      logic [2:0]  npix;
      logic [31:0] idx;
   } csd_event_type;

endpackage

// ===== sv/csd_ram.sv =====
// ----------------------------------------------------------------------------
// csd_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// A read and a write of the same entry in one cycle return the old contents.
// ----------------------------------------------------------------------------
module csd_ram #(
   parameter int  WIDTH  = 24,
   parameter int  DEPTH  = 256,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/csd_decode.sv =====
// ----------------------------------------------------------------------------
// csd_decode
// Code byte interpreter: decode state, row base, configuration registers.
// Turns each accepted code byte into at most one event for the result side.
// ----------------------------------------------------------------------------
module csd_decode import csd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_write,
   input  logic          csr_index,
   input  logic [12:0]   csr_wdata,
   input  logic          byte_en,
   input  logic [7:0]    code_byte,
   input  logic [11:0]   row_index,
   input  logic          first_of_row,
   input  logic          first_of_frame,
   input  logic          end_of_frame,
   output csd_event_type evt
);

   localparam logic [3:0] PH_IDLE     = 4'd0;
   localparam logic [3:0] PH_OP       = 4'd1;
   localparam logic [3:0] PH_ADD      = 4'd2;
   localparam logic [3:0] PH_PFX66    = 4'd3;
   localparam logic [3:0] PH_MODRM    = 4'd4;
   localparam logic [3:0] PH_DISP     = 4'd5;
   localparam logic [3:0] PH_DISP_BAD = 4'd6;
   localparam logic [3:0] PH_DATA     = 4'd7;
   localparam logic [3:0] PH_DATA_BAD = 4'd8;

   localparam logic [7:0] OPC_RET   = 8'hc3;
   localparam logic [7:0] OPC_ADD   = 8'h05;
   localparam logic [7:0] OPC_MOVB  = 8'hc6;
   localparam logic [7:0] OPC_MOVD  = 8'hc7;
   localparam logic [7:0] OPC_OSIZE = 8'h66;
   localparam logic [7:0] MODRM_OK  = 8'h40;

   localparam logic [2:0] ERR_NO_PALETTE = 3'd0;
   localparam logic [2:0] ERR_BAD_OPCODE = 3'd1;
   localparam logic [2:0] ERR_BAD_MODRM  = 3'd2;
   localparam logic [2:0] ERR_TRUNCATED  = 3'd3;
   localparam logic [2:0] ERR_BOUNDS     = 3'd4;
   localparam logic [2:0] ERR_NO_RETURN  = 3'd5;

   localparam logic [0:0] CSR_PALETTE = 1'd0;
   localparam logic [0:0] CSR_WIDTH   = 1'd1;

   localparam logic signed [41:0] MAX_W = 42'(MAX_WIDTH);

   logic [3:0]         phase_ff, phase_in;
   logic [2:0]         len_ff, len_in;
   logic [2:0]         cnt_ff, cnt_in;
   logic [31:0]        acc_ff, acc_in;
   logic signed [39:0] base_ff, base_in;
   logic [31:0]        idx_ff, idx_in;
   logic               sticky_ff, sticky_in;
   logic               pal_present_ff;
   logic [12:0]        row_width_ff;

   logic [31:0]        byte_shifted;
   logic [31:0]        acc_full;
   logic signed [40:0] add_sum;
   logic signed [39:0] base_sat;
   logic signed [40:0] x0;
   logic signed [41:0] x_end;
   logic signed [41:0] w_lim;
   logic signed [41:0] w_cfg;
   logic               fail;
   logic [2:0]         fail_code;
   logic               ret;
   logic [2:0]         npix;

   assign byte_shifted = {24'd0, code_byte} << {cnt_ff[1:0], 3'd0};
   assign acc_full     = acc_ff | byte_shifted;

   // saturating add of the signed immediate to the 40-bit base
   assign add_sum  = {base_ff[39], base_ff} + {{9{acc_full[31]}}, acc_full};
   assign base_sat = (add_sum[40] != add_sum[39]) ?
                     {add_sum[40], {39{~add_sum[40]}}} : add_sum[39:0];

   assign x0    = {base_ff[39], base_ff} + {{33{acc_ff[7]}}, acc_ff[7:0]};
   assign x_end = {x0[40], x0} + {39'd0, len_ff};
   assign w_cfg = {29'd0, row_width_ff};
   assign w_lim = (w_cfg > MAX_W) ? MAX_W : w_cfg;

   always_comb begin
      phase_in  = phase_ff;
      len_in    = len_ff;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      base_in   = base_ff;
      idx_in    = idx_ff;
      sticky_in = sticky_ff;
      fail      = 1'b0;
      fail_code = ERR_NO_PALETTE;
      ret       = 1'b0;
      npix      = 3'd0;

      if (first_of_frame) begin
         sticky_in = 1'b0;
         phase_in  = PH_IDLE;
         base_in   = '0;
      end

      if (!sticky_in) begin
         if (!pal_present_ff) begin
            fail      = 1'b1;
            fail_code = ERR_NO_PALETTE;
         end else begin
            if (first_of_row || first_of_frame) begin
               if (phase_in == PH_OP) begin
                  fail      = 1'b1;
                  fail_code = ERR_NO_RETURN;
               end else if (phase_in != PH_IDLE) begin
                  fail      = 1'b1;
                  fail_code = ERR_TRUNCATED;
               end else begin
                  base_in  = '0;
                  phase_in = PH_OP;
               end
            end

            if (!fail && phase_in != PH_IDLE) begin
               case (phase_in)
                  PH_OP: begin
                     case (code_byte)
                        OPC_RET: begin
                           ret      = 1'b1;
                           phase_in = PH_IDLE;
                        end
                        OPC_ADD: begin
                           acc_in   = '0;
                           cnt_in   = '0;
                           phase_in = PH_ADD;
                        end
                        OPC_MOVB: begin
                           len_in   = 3'd1;
                           phase_in = PH_MODRM;
                        end
                        OPC_MOVD: begin
                           len_in   = 3'd4;
                           phase_in = PH_MODRM;
                        end
                        OPC_OSIZE: begin
                           if (end_of_frame) begin
                              fail      = 1'b1;
                              fail_code = ERR_BAD_OPCODE;
                           end else begin
                              phase_in = PH_PFX66;
                           end
                        end
                        default: begin
                           fail      = 1'b1;
                           fail_code = ERR_BAD_OPCODE;
                        end
                     endcase
                  end
                  PH_ADD: begin
                     acc_in = acc_full;
                     cnt_in = cnt_ff + 3'd1;
                     if (cnt_in >= 3'd4) begin
                        base_in  = base_sat;
                        phase_in = PH_OP;
                     end
                  end
                  PH_PFX66: begin
                     if (code_byte != OPC_MOVD || end_of_frame) begin
                        fail      = 1'b1;
                        fail_code = ERR_BAD_OPCODE;
                     end else begin
                        len_in   = 3'd2;
                        phase_in = PH_MODRM;
                     end
                  end
                  PH_MODRM: begin
                     phase_in = (code_byte == MODRM_OK) ? PH_DISP : PH_DISP_BAD;
                  end
                  PH_DISP, PH_DISP_BAD: begin
                     acc_in   = {24'd0, code_byte};
                     cnt_in   = '0;
                     idx_in   = '0;
                     phase_in = (phase_ff == PH_DISP) ? PH_DATA : PH_DATA_BAD;
                  end
                  PH_DATA, PH_DATA_BAD: begin
                     idx_in = idx_ff | byte_shifted;
                     cnt_in = cnt_ff + 3'd1;
                     if (cnt_in >= len_ff) begin
                        if (phase_ff == PH_DATA_BAD) begin
                           fail      = 1'b1;
                           fail_code = ERR_BAD_MODRM;
                        end else if (x0[40] || x_end > w_lim) begin
                           fail      = 1'b1;
                           fail_code = ERR_BOUNDS;
                        end else begin
                           npix     = len_ff;
                           phase_in = PH_OP;
                        end
                     end
                  end
                  default: begin
                     phase_in = PH_IDLE;
                  end
               endcase
            end

            // frame closed without ret: pixels of this byte are dropped
            if (!fail && end_of_frame && phase_in != PH_IDLE) begin
               fail      = 1'b1;
               fail_code = (phase_in == PH_OP) ? ERR_NO_RETURN : ERR_TRUNCATED;
            end
         end

         if (fail) begin
            sticky_in = 1'b1;
            phase_in  = PH_IDLE;
         end
      end
   end

   always_comb begin
      evt = '0;
      if (fail) begin
         evt.valid = 1'b1;
         evt.kind  = KIND_ERROR;
         evt.err   = fail_code;
         evt.npix  = 3'd1;
      end else if (ret) begin
         evt.valid = 1'b1;
         evt.kind  = KIND_ROW;
         evt.y     = row_index;
         evt.npix  = 3'd1;
      end else if (npix != 3'd0) begin
         evt.valid = 1'b1;
         evt.kind  = KIND_PIXEL;
         evt.x0    = x0[11:0];
         evt.y     = row_index;
         evt.npix  = npix;
         evt.idx   = idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         len_ff         <= '0;
         cnt_ff         <= '0;
         acc_ff         <= '0;
         base_ff        <= '0;
         idx_ff         <= '0;
         sticky_ff      <= 1'b0;
         pal_present_ff <= 1'b0;
         row_width_ff   <= 13'd1;
      end else begin
         if (byte_en) begin
            phase_ff  <= phase_in;
            len_ff    <= len_in;
            cnt_ff    <= cnt_in;
            acc_ff    <= acc_in;
            base_ff   <= base_in;
            idx_ff    <= idx_in;
            sticky_ff <= sticky_in;
         end
         if (csr_write && csr_index == CSR_PALETTE) begin
            pal_present_ff <= csr_wdata[0];
         end
         if (csr_write && csr_index == CSR_WIDTH) begin
            row_width_ff <= csr_wdata;
         end
      end
   end

endmodule

// ===== sv/compiled_sprite_scanline_decoder.sv =====
// ----------------------------------------------------------------------------
// compiled_sprite_scanline_decoder
// Interprets compiled-sprite scanline code and emits palette-mapped pixels,
// row-finished markers and sticky errors.
// ----------------------------------------------------------------------------
//  port group | direction | handshake       | carries
//  req_*      | in        | valid / stall   | code byte or palette entry load
//  rsp_*      | out       | valid / stall   | pixel, row finished or error
//  csr_*      | in        | write enable    | palette_present, row_width
//
// One request per cycle unless the output stalls; a request yielding n results
// (n up to 4 for a dword store) holds the next request until the last of them
// is issued to the palette read port, which serves one lookup per cycle.
// Results pass the held event register, the lookup stage and the output register.
// Reset is synchronous; the palette RAM has no reset and holds garbage until
// loaded. Palette loads wait behind any event still being issued.
// ----------------------------------------------------------------------------
module compiled_sprite_scanline_decoder import csd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [7:0]  req_code_byte,
   input  logic [7:0]  req_palette_slot,
   input  logic [23:0] req_palette_rgb,
   input  logic [11:0] req_row_index,
   input  logic        req_first_of_row,
   input  logic        req_first_of_frame,
   input  logic        req_end_of_frame,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [2:0]  rsp_error_code,
   output logic [11:0] rsp_pixel_x,
   output logic [11:0] rsp_pixel_y,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic        rsp_last,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [12:0] csr_wdata
);

   localparam logic OP_CODE = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   csd_event_type dec_evt;
   csd_event_type evt_ff, evt_in;
   logic [1:0]    sel_ff, sel_in;

   logic          rd_valid_ff, rd_valid_in;
   logic [1:0]    rd_kind_ff, rd_kind_in;
   logic [2:0]    rd_err_ff, rd_err_in;
   logic [11:0]   rd_x_ff, rd_x_in;
   logic [11:0]   rd_y_ff, rd_y_in;
   logic          rd_last_ff, rd_last_in;

   logic          out_valid_ff, out_valid_in;
   logic [1:0]    out_kind_ff, out_kind_in;
   logic [2:0]    out_err_ff, out_err_in;
   logic [11:0]   out_x_ff, out_x_in;
   logic [11:0]   out_y_ff, out_y_in;
   logic [23:0]   out_rgb_ff, out_rgb_in;
   logic          out_last_ff, out_last_in;

   logic                  accept;
   logic                  byte_en;
   logic                  out_free;
   logic                  rd_move;
   logic                  rd_free;
   logic                  issue;
   logic                  issue_last;
   logic                  pal_we;
   logic                  pal_re;
   logic [PAL_ADDR_W-1:0] pal_raddr;
   logic [RGB_W-1:0]      pal_rdata;
   logic [31:0]           idx_shifted;

   assign out_free   = !out_valid_ff || !rsp_stall;
   assign rd_move    = rd_valid_ff && out_free;
   assign rd_free    = !rd_valid_ff || out_free;
   assign issue      = evt_ff.valid && rd_free;
   assign issue_last = issue && ({1'b0, sel_ff} == evt_ff.npix - 3'd1);

   // a new request may enter once the held event has issued its last result
   assign req_stall = evt_ff.valid && !issue_last;
   assign accept    = req_valid && !req_stall;
   assign byte_en   = accept && req_opcode == OP_CODE;
   assign pal_we    = accept && req_opcode == OP_LOAD;

   csd_decode u_decode (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .byte_en        (byte_en),
      .code_byte      (req_code_byte),
      .row_index      (req_row_index),
      .first_of_row   (req_first_of_row),
      .first_of_frame (req_first_of_frame),
      .end_of_frame   (req_end_of_frame),
      .evt            (dec_evt)
   );

   assign idx_shifted = evt_ff.idx >> {sel_ff, 3'd0};
   assign pal_raddr   = idx_shifted[PAL_ADDR_W-1:0];
   assign pal_re      = issue && evt_ff.kind == KIND_PIXEL;

   // read-first: a load taken with the last lookup does not affect it
   csd_ram #(
      .WIDTH (RGB_W),
      .DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock (clock),
      .we    (pal_we),
      .waddr (req_palette_slot),
      .wdata (req_palette_rgb),
      .re    (pal_re),
      .raddr (pal_raddr),
      .rdata (pal_rdata)
   );

   always_comb begin
      evt_in = evt_ff;
      sel_in = sel_ff;
      if (byte_en && dec_evt.valid) begin
         evt_in = dec_evt;
         sel_in = '0;
      end else if (issue_last) begin
         evt_in.valid = 1'b0;
      end else if (issue) begin
         sel_in = sel_ff + 2'd1;
      end
   end

   always_comb begin
      rd_valid_in = rd_valid_ff;
      rd_kind_in  = rd_kind_ff;
      rd_err_in   = rd_err_ff;
      rd_x_in     = rd_x_ff;
      rd_y_in     = rd_y_ff;
      rd_last_in  = rd_last_ff;
      if (issue) begin
         rd_valid_in = 1'b1;
         rd_kind_in  = evt_ff.kind;
         rd_err_in   = evt_ff.err;
         rd_x_in     = (evt_ff.kind == KIND_PIXEL) ? evt_ff.x0 + {10'd0, sel_ff} : '0;
         rd_y_in     = evt_ff.y;
         rd_last_in  = issue_last;
      end else if (rd_move) begin
         rd_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_kind_in  = out_kind_ff;
      out_err_in   = out_err_ff;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_rgb_in   = out_rgb_ff;
      out_last_in  = out_last_ff;
      if (rd_move) begin
         out_valid_in = 1'b1;
         out_kind_in  = rd_kind_ff;
         out_err_in   = rd_err_ff;
         out_x_in     = rd_x_ff;
         out_y_in     = rd_y_ff;
         out_rgb_in   = (rd_kind_ff == KIND_PIXEL) ? pal_rdata : '0;
         out_last_in  = rd_last_ff;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         evt_ff.valid <= 1'b0;
         sel_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         evt_ff.valid <= evt_in.valid;
         sel_ff       <= sel_in;
         rd_valid_ff  <= rd_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      evt_ff.kind <= evt_in.kind;
      evt_ff.err  <= evt_in.err;
      evt_ff.x0   <= evt_in.x0;
      evt_ff.y    <= evt_in.y;
      evt_ff.npix <= evt_in.npix;
      evt_ff.idx  <= evt_in.idx;
      rd_kind_ff  <= rd_kind_in;
      rd_err_ff   <= rd_err_in;
      rd_x_ff     <= rd_x_in;
      rd_y_ff     <= rd_y_in;
      rd_last_ff  <= rd_last_in;
      out_kind_ff <= out_kind_in;
      out_err_ff  <= out_err_in;
      out_x_ff    <= out_x_in;
      out_y_ff    <= out_y_in;
      out_rgb_ff  <= out_rgb_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_kind       = out_kind_ff;
   assign rsp_error_code = out_err_ff;
   assign rsp_pixel_x    = out_x_ff;
   assign rsp_pixel_y    = out_y_ff;
   assign rsp_red        = out_rgb_ff[23:16];
   assign rsp_green      = out_rgb_ff[15:8];
   assign rsp_blue       = out_rgb_ff[7:0];
   assign rsp_last       = out_last_ff;

   a_evt_count: assert property (@(posedge clock) disable iff (reset)
      evt_ff.valid |-> (evt_ff.npix != 3'd0 && evt_ff.npix <= 3'd4))
      else $error("held event with impossible result count");

   a_load_order: assert property (@(posedge clock) disable iff (reset)
      pal_we |-> (!evt_ff.valid || issue_last))
      else $error("palette load overtook a pending lookup");

   a_rd_hold: assert property (@(posedge clock) disable iff (reset)
      (rd_valid_ff && !out_free) |=> (rd_valid_ff && !$past(pal_re) && $stable(rd_x_ff)))
      else $error("lookup stage lost its data while the output was stalled");

   a_err_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == KIND_ERROR || rsp_kind == KIND_ROW)) |-> rsp_last)
      else $error("error or row result not marked last");

endmodule
